// ===== src/sawcl_pkg.sv =====
// Package for the set-associative write-back cache tag store with LRU replacement.
// Holds widths, register indexes, controller states and the command and status types.
// Used by every module of the block; it depends on nothing.
`default_nettype none

package sawcl_pkg;

   localparam int DEF_MAX_SETS = 1024;
   localparam int DEF_MAX_WAYS = 16;

   localparam int ADDR_W        = 32;
   localparam int OFFSET_W      = 4;
   localparam int INDEX_W       = 4;
   localparam int WAYS_CFG_W    = 5;
   localparam int WAY_OUT_W     = 4;
   localparam int INDEX_FIELD_W = 15;
   localparam int SHIFT_W       = 5;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 5;
   localparam int RSP_TDATA_W   = 72;
   localparam int RSP_TUSER_W   = 3;

   localparam logic [OFFSET_W-1:0]   OFFSET_RESET = 4'd5;
   localparam logic [INDEX_W-1:0]    INDEX_RESET  = 4'd6;
   localparam logic [WAYS_CFG_W-1:0] WAYS_RESET   = 5'd4;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_WAYS_IN_USE = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic div_en;
      logic read_en;
      logic lookup_en;
      logic update_en;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic slot_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== src/set_assoc_writeback_cache_lru.sv =====
// Top level of the set-associative write-back cache tag store with LRU replacement.
// Instantiates sawcl_ctrl and sawcl_datapath; depends on sawcl_pkg.
`default_nettype none

// Each request word carries an access (read or write) and a byte address; each
// response word reports hit or miss, the way used, a writeback of a dirty victim and
// the fetch of a missed line. After reset the block first clears every row of its set
// memory and accepts no request until that is done; configuration writes are
// taken at any time. A request then runs through five steps: acceptance, the reciprocal
// multiply that maps the index field onto a set, the read of the set's row, the way
// lookup, and the write-back of the row together with loading the response register.
// A new request is taken in the cycle after that, so the block takes no new word
// before it is through with the last; the last step waits while the response register
// still holds a word that the response side has not taken.

module set_assoc_writeback_cache_lru #(
   parameter int MAX_SETS = sawcl_pkg::DEF_MAX_SETS,
   parameter int MAX_WAYS = sawcl_pkg::DEF_MAX_WAYS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [sawcl_pkg::ADDR_W-1:0]      req_tdata,   // address
   input  wire logic                              req_tuser,   // opcode
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // way_used [3:0], writeback_address [35:4], fetch_address [67:36], zero fill
   output logic [sawcl_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // hit [0], writeback_valid [1], fetch_valid [2]
   output logic [sawcl_pkg::RSP_TUSER_W-1:0]      rsp_tuser,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sawcl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sawcl_pkg::CSR_DATA_W-1:0]  csr_data
);

   sawcl_pkg::ctrl_cmd_type  cmd;
   sawcl_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   sawcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sawcl_datapath #(
      .MAX_SETS (MAX_SETS),
      .MAX_WAYS (MAX_WAYS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== src/sawcl_ctrl.sv =====
// Controller state machine of the cache tag store.
// Sequences the clearing pass and the steps of one access; depends on sawcl_pkg.
`default_nettype none

module sawcl_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire sawcl_pkg::dp_status_type status,
   output sawcl_pkg::ctrl_cmd_type       cmd
);

   sawcl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sawcl_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sawcl_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = sawcl_pkg::ST_IDLE;
         end
         sawcl_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = sawcl_pkg::ST_DIVIDE;
         end
         sawcl_pkg::ST_DIVIDE: state_in = sawcl_pkg::ST_READ;
         sawcl_pkg::ST_READ:   state_in = sawcl_pkg::ST_LOOKUP;
         sawcl_pkg::ST_LOOKUP: state_in = sawcl_pkg::ST_UPDATE;
         sawcl_pkg::ST_UPDATE: begin
            if (status.slot_free) state_in = sawcl_pkg::ST_IDLE;
         end
         default: state_in = sawcl_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         sawcl_pkg::ST_CLEAR:  cmd.clear_en = 1'b1;
         sawcl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         sawcl_pkg::ST_DIVIDE: cmd.div_en    = 1'b1;
         sawcl_pkg::ST_READ:   cmd.read_en   = 1'b1;
         sawcl_pkg::ST_LOOKUP: cmd.lookup_en = 1'b1;
         sawcl_pkg::ST_UPDATE: cmd.update_en = status.slot_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/sawcl_datapath.sv =====
// Datapath of the cache tag store: configuration registers, address split, set memory,
// way lookup, LRU update and the result register. Depends on sawcl_pkg.
`default_nettype none

module sawcl_datapath #(
   parameter int MAX_SETS = sawcl_pkg::DEF_MAX_SETS,
   parameter int MAX_WAYS = sawcl_pkg::DEF_MAX_WAYS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire sawcl_pkg::ctrl_cmd_type               cmd,
   output sawcl_pkg::dp_status_type                   status,
   input  wire logic                                  csr_valid,
   input  wire logic [sawcl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [sawcl_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire logic [sawcl_pkg::ADDR_W-1:0]          req_tdata,
   input  wire logic                                  req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [sawcl_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   output logic [sawcl_pkg::RSP_TUSER_W-1:0]          rsp_tuser
);

   localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W = WAY_W;
   localparam int NW_W   = $clog2(MAX_WAYS + 1);
   localparam int AW     = sawcl_pkg::ADDR_W;
   localparam int IFW    = sawcl_pkg::INDEX_FIELD_W;
   localparam logic [32:0] RECIP =
      33'(((64'd1 << 32) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS));
   localparam logic [32:0] SETS_C = 33'(MAX_SETS);

   typedef struct packed {
      logic              valid;
      logic              dirty;
      logic [AW-1:0]     tag;
      logic [AW-1:0]     addr;
      logic [RANK_W-1:0] rank;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] row_type;

   // Configuration registers.
   logic [sawcl_pkg::OFFSET_W-1:0]   offset_ff, offset_in;
   logic [sawcl_pkg::INDEX_W-1:0]    ibits_ff, ibits_in;
   logic [sawcl_pkg::WAYS_CFG_W-1:0] ways_ff, ways_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= sawcl_pkg::OFFSET_RESET;
         ibits_ff  <= sawcl_pkg::INDEX_RESET;
         ways_ff   <= sawcl_pkg::WAYS_RESET;
      end else begin
         offset_ff <= offset_in;
         ibits_ff  <= ibits_in;
         ways_ff   <= ways_in;
      end
   end

   always_comb begin
      offset_in = offset_ff;
      ibits_in  = ibits_ff;
      ways_in   = ways_ff;
      if (csr_valid) begin
         case (csr_index)
            sawcl_pkg::CSR_OFFSET_BITS: offset_in = csr_data[sawcl_pkg::OFFSET_W-1:0];
            sawcl_pkg::CSR_INDEX_BITS:  ibits_in  = csr_data[sawcl_pkg::INDEX_W-1:0];
            sawcl_pkg::CSR_WAYS_IN_USE: ways_in   = csr_data[sawcl_pkg::WAYS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   logic [NW_W-1:0] eff_ways;

   always_comb begin
      if (ways_ff == '0) begin
         eff_ways = NW_W'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         eff_ways = NW_W'(MAX_WAYS);
      end else begin
         eff_ways = NW_W'(ways_ff);
      end
   end

   // Address split on acceptance.
   logic                               op_ff;
   logic [AW-1:0]                      addr_ff;
   logic [AW-1:0]                      tag_ff;
   logic [IFW-1:0]                     ifield_ff;
   logic [AW-1:0]                      set_mask;
   logic [sawcl_pkg::SHIFT_W-1:0]      tag_shift;

   assign set_mask  = (AW'(1) << ibits_ff) - AW'(1);
   assign tag_shift = {1'b0, ibits_ff} + {1'b0, offset_ff};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_tuser;
         addr_ff   <= req_tdata;
         tag_ff    <= req_tdata >> tag_shift;
         ifield_ff <= IFW'((req_tdata >> offset_ff) & set_mask);
      end
   end

   // Set number as the index field modulo MAX_SETS, by reciprocal multiplication.
   logic [47:0] quo_prod;
   logic [15:0] quo_ff;
   logic [32:0] quo_times_sets;
   logic [32:0] rem_full;
   logic [SET_W-1:0] set_w;
   logic [SET_W-1:0] set_ff;

   assign quo_prod       = 48'(ifield_ff) * 48'(RECIP);
   assign quo_times_sets = 33'(quo_ff) * SETS_C;
   assign rem_full       = 33'(ifield_ff) - quo_times_sets;
   assign set_w          = rem_full[SET_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_en) quo_ff <= quo_prod[47:32];
      if (cmd.read_en) set_ff <= set_w;
   end

   // Set memory, one row per set, and the clearing pass after reset.
   row_type          row_mem [MAX_SETS];
   row_type          rd_row_ff;
   row_type          init_row;
   row_type          upd_row;
   logic [SET_W-1:0] clr_ff, clr_in;
   logic             mem_we;
   logic [SET_W-1:0] mem_waddr;
   row_type          mem_wdata;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         init_row[w]      = '0;
         init_row[w].rank = RANK_W'(w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   assign clr_in            = cmd.clear_en ? clr_ff + SET_W'(1) : clr_ff;
   assign status.clear_last = (clr_ff == SET_W'(MAX_SETS - 1));

   assign mem_we    = cmd.clear_en || cmd.update_en;
   assign mem_waddr = cmd.clear_en ? clr_ff : set_ff;
   assign mem_wdata = cmd.clear_en ? init_row : upd_row;

   always_ff @(posedge clock) begin
      if (mem_we) row_mem[mem_waddr] <= mem_wdata;
      if (cmd.read_en) rd_row_ff <= row_mem[set_w];
   end

   // Lookup: hit search and victim choice.
   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] match;
   logic [MAX_WAYS-1:0] match_low;
   logic [MAX_WAYS-1:0] win;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    vic_way;
   logic                hit_ff;
   logic [WAY_W-1:0]    pick_ff;

   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         in_use[i] = (NW_W'(i) < eff_ways);
         match[i]  = in_use[i] && rd_row_ff[i].valid && (rd_row_ff[i].tag == tag_ff);
      end
      match_low = match & (~match + MAX_WAYS'(1));
      hit_way   = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (match_low[i]) hit_way = hit_way | WAY_W'(i);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         win[i] = in_use[i];
         for (int j = 0; j < MAX_WAYS; j++) begin
            if (in_use[j] && (j < i) && (rd_row_ff[i].rank < rd_row_ff[j].rank)) begin
               win[i] = 1'b0;
            end
            if (in_use[j] && (j > i) && (rd_row_ff[i].rank <= rd_row_ff[j].rank)) begin
               win[i] = 1'b0;
            end
         end
      end
      vic_way = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (win[i]) vic_way = vic_way | WAY_W'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup_en) begin
         hit_ff  <= |match;
         pick_ff <= (|match) ? hit_way : vic_way;
      end
   end

   // Update of the row and the result.
   logic [RANK_W-1:0] old_rank;
   line_type          pick_line;

   assign pick_line = rd_row_ff[pick_ff];
   assign old_rank  = pick_line.rank;

   always_comb begin
      upd_row = rd_row_ff;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WAY_W'(i) == pick_ff) begin
            upd_row[i].rank = '0;
            upd_row[i].addr = addr_ff;
            if (hit_ff) begin
               upd_row[i].dirty = rd_row_ff[i].dirty || (op_ff == sawcl_pkg::OP_WRITE);
            end else begin
               upd_row[i].valid = 1'b1;
               upd_row[i].dirty = (op_ff == sawcl_pkg::OP_WRITE);
               upd_row[i].tag   = tag_ff;
            end
         end else if (in_use[i] && (rd_row_ff[i].rank < old_rank)) begin
            upd_row[i].rank = rd_row_ff[i].rank + RANK_W'(1);
         end
      end
   end

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sawcl_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic [sawcl_pkg::RSP_TUSER_W-1:0] rsp_user_ff;
   logic                              wb_valid;
   logic [AW-1:0]                     wb_addr;
   logic [AW-1:0]                     fetch_addr;

   assign wb_valid   = !hit_ff && pick_line.dirty;
   assign wb_addr    = wb_valid ? pick_line.addr : '0;
   assign fetch_addr = hit_ff ? '0 : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = cmd.update_en || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (cmd.update_en) begin
         rsp_data_ff <= {4'd0, fetch_addr, wb_addr, sawcl_pkg::WAY_OUT_W'(pick_ff)};
         rsp_user_ff <= {!hit_ff, wb_valid, hit_ff};
      end
   end

   assign status.slot_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;
   assign rsp_tuser        = rsp_user_ff;

endmodule

`default_nettype wire

// ===== test/set_assoc_writeback_cache_lru_test.sv =====
// Self-checking testbench for the set-associative write-back cache tag store with LRU.
// A scoreboard class predicts every response word from its own copy of the tag store.
// It depends on sawcl_pkg and set_assoc_writeback_cache_lru and on nothing else.
`timescale 1ns / 1ps

module set_assoc_writeback_cache_lru_test;
   import sawcl_pkg::*;

   localparam int NUM_LINES      = DEF_MAX_SETS * DEF_MAX_WAYS;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam int SETTLE_CYCLES  = 10;
   localparam int TAIL_CYCLES    = 20;
   localparam int NUM_PHASES     = 10;
   localparam int PHASE_ACCESSES = 200;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic                 wb_valid;
      logic [ADDR_W-1:0]    wb_addr;
      logic                 fetch_valid;
      logic [ADDR_W-1:0]    fetch_addr;
   } access_outcome_type;

   class cache_scoreboard;
      bit                   line_present[NUM_LINES];
      bit                   line_modified[NUM_LINES];
      logic [ADDR_W-1:0]    line_tag_mem[NUM_LINES];
      logic [ADDR_W-1:0]    line_last_addr[NUM_LINES];
      logic [3:0]           line_age[NUM_LINES];
      int unsigned          off_cfg;
      int unsigned          idx_cfg;
      int unsigned          ways_cfg;
      access_outcome_type   outcome_q[$];
      int unsigned          mismatches;
      int unsigned          checked;
      int unsigned          hits;
      int unsigned          writebacks;

      function new();
         for (int i = 0; i < NUM_LINES; i++) begin
            line_present[i]   = 1'b0;
            line_modified[i]  = 1'b0;
            line_tag_mem[i]   = '0;
            line_last_addr[i] = '0;
            line_age[i]       = 4'(i % DEF_MAX_WAYS);
         end
         off_cfg    = OFFSET_RESET;
         idx_cfg    = INDEX_RESET;
         ways_cfg   = WAYS_RESET;
         mismatches = 0;
         checked    = 0;
         hits       = 0;
         writebacks = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_OFFSET_BITS: begin
               off_cfg = data[3:0];
            end
            CSR_INDEX_BITS: begin
               idx_cfg = data[3:0];
            end
            CSR_WAYS_IN_USE: begin
               ways_cfg = data;
            end
            default: begin
            end
         endcase
      endfunction

      function void promote_way(int unsigned base, int unsigned nways, int unsigned pick);
         logic [3:0] old_age;
         old_age = line_age[base + pick];
         for (int unsigned i = 0; i < nways; i++) begin
            if (i != pick && line_age[base + i] < old_age) begin
               line_age[base + i] = line_age[base + i] + 4'd1;
            end
         end
         line_age[base + pick] = 4'd0;
      endfunction

      function void note_access(logic op, logic [ADDR_W-1:0] addr);
         access_outcome_type o;
         int unsigned     nways;
         int unsigned     set_no;
         int unsigned     base;
         int unsigned     pick;
         logic [ADDR_W-1:0] tag;
         logic [3:0]      oldest;
         bit              found;
         nways = (ways_cfg == 0) ? 1 : ((ways_cfg > DEF_MAX_WAYS) ? DEF_MAX_WAYS : ways_cfg);
         set_no = ((addr >> off_cfg) & ((32'd1 << idx_cfg) - 32'd1)) % DEF_MAX_SETS;
         tag = addr >> (idx_cfg + off_cfg);
         base = set_no * DEF_MAX_WAYS;
         o = '0;
         found = 1'b0;
         pick = 0;
         for (int unsigned i = 0; i < nways; i++) begin
            if (!found && line_present[base + i] && line_tag_mem[base + i] == tag) begin
               found = 1'b1;
               pick = i;
            end
         end
         if (found) begin
            promote_way(base, nways, pick);
            if (op == OP_WRITE) begin
               line_modified[base + pick] = 1'b1;
            end
            line_last_addr[base + pick] = addr;
            o.hit = 1'b1;
            o.way = 4'(pick);
         end else begin
            oldest = line_age[base];
            for (int unsigned i = 1; i < nways; i++) begin
               if (line_age[base + i] >= oldest) begin
                  oldest = line_age[base + i];
                  pick = i;
               end
            end
            promote_way(base, nways, pick);
            if (line_modified[base + pick]) begin
               o.wb_valid = 1'b1;
               o.wb_addr = line_last_addr[base + pick];
            end
            line_present[base + pick]   = 1'b1;
            line_modified[base + pick]  = (op == OP_WRITE);
            line_tag_mem[base + pick]   = tag;
            line_last_addr[base + pick] = addr;
            o.way = 4'(pick);
            o.fetch_valid = 1'b1;
            o.fetch_addr = addr;
         end
         outcome_q.push_back(o);
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] data, logic [RSP_TUSER_W-1:0] user);
         access_outcome_type want;
         access_outcome_type got;
         got.hit         = user[0];
         got.wb_valid    = user[1];
         got.fetch_valid = user[2];
         got.way         = data[3:0];
         got.wb_addr     = data[35:4];
         got.fetch_addr  = data[67:36];
         if (outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Unexpected response word: hit=%0b way=%0d wb=%0b/%08h fetch=%0b/%08h",
                        got.hit, got.way, got.wb_valid, got.wb_addr, got.fetch_valid,
                        got.fetch_addr);
            end
            return;
         end
         want = outcome_q.pop_front();
         checked++;
         if (want.hit) begin
            hits++;
         end
         if (want.wb_valid) begin
            writebacks++;
         end
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Response %0d differs: expected hit=%0b way=%0d wb=%0b/%08h %s%0b/%08h",
                        checked, want.hit, want.way, want.wb_valid, want.wb_addr,
                        "fetch=", want.fetch_valid, want.fetch_addr);
               $display("                      actual   hit=%0b way=%0d wb=%0b/%08h %s%0b/%08h",
                        got.hit, got.way, got.wb_valid, got.wb_addr,
                        "fetch=", got.fetch_valid, got.fetch_addr);
            end
         end
      endfunction

      function int unsigned pending();
         return outcome_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ADDR_W-1:0]      req_tdata = '0;
   logic                   req_tuser = OP_READ;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_OFFSET_BITS;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   cache_scoreboard sb;
   int unsigned     idle_cycles = 0;
   int unsigned     burst_left = 0;
   int unsigned     settings_used = 1;

   set_assoc_writeback_cache_lru dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timed out after %0d cycles without a handshake.", idle_cycles);
         $display("set_assoc_writeback_cache_lru_test: FAIL");
         $finish;
      end
   end

   // The response side alternates between free flow, random patterns, stalls and plain toggling.
   initial begin
      int unsigned       mode;
      logic [31:0]       pattern;
      forever begin
         mode = $urandom_range(0, 3);
         case (mode)
            0: begin
               repeat ($urandom_range(10, 60)) begin
                  @(negedge clock);
                  rsp_tready <= 1'b1;
               end
            end
            1: begin
               pattern = $urandom;
               for (int k = 0; k < 32; k++) begin
                  @(negedge clock);
                  rsp_tready <= pattern[k];
               end
            end
            2: begin
               repeat ($urandom_range(1, 20)) begin
                  @(negedge clock);
                  rsp_tready <= 1'b0;
               end
            end
            default: begin
               repeat ($urandom_range(4, 30)) begin
                  @(negedge clock);
                  rsp_tready <= ~rsp_tready;
               end
            end
         endcase
      end
   end

   task automatic drive_access(logic op, logic [ADDR_W-1:0] addr);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      req_tuser  <= op;
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_access(op, addr);
   endtask

   task automatic pause_sender(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= 1'($urandom_range(0, 1));
      end
   endtask

   task automatic drain_responses();
      pause_sender(1);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_setting(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      sb.write_reg(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(int unsigned offset, int unsigned index, int unsigned ways);
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_setting(CSR_OFFSET_BITS, {1'($urandom_range(0, 1)), 4'(offset)});
      write_setting(CSR_INDEX_BITS, {1'($urandom_range(0, 1)), 4'(index)});
      write_setting(CSR_WAYS_IN_USE, 5'(ways));
      settings_used++;
   endtask

   // Most addresses fall on a few sets and a few tags of the current geometry, so that
   // hits, evictions and dirty writebacks are frequent.
   function automatic logic [ADDR_W-1:0] pick_address();
      int unsigned       sel;
      logic [ADDR_W-1:0] tag_part;
      logic [ADDR_W-1:0] set_part;
      logic [ADDR_W-1:0] byte_part;
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
         return $urandom;
      end
      set_part = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom;
      set_part = (set_part & ((32'd1 << sb.idx_cfg) - 32'd1)) << sb.off_cfg;
      byte_part = $urandom & ((32'd1 << sb.off_cfg) - 32'd1);
      tag_part = (sel < 9) ? $urandom_range(0, 19) : ~$urandom_range(0, 3);
      tag_part = tag_part << (sb.idx_cfg + sb.off_cfg);
      return tag_part | set_part | byte_part;
   endfunction

   task automatic send_random(int unsigned count);
      int unsigned gap;
      for (int unsigned k = 0; k < count; k++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               pause_sender(gap);
            end
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
         if (k == count / 2) begin
            drain_responses();
         end
         drive_access(1'($urandom_range(0, 1)), pick_address());
      end
   endtask

   initial begin
      int unsigned fixed_off[7];
      int unsigned fixed_idx[7];
      int unsigned fixed_ways[7];
      fixed_off  = '{0, 12, 15, 13, 2, 4, 1};
      fixed_idx  = '{0, 10, 15, 11, 3, 12, 1};
      fixed_ways = '{1, 16, 31, 0, 2, 17, 8};
      sb = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed accesses with the reset geometry: 32-byte lines, 64 sets, 4 ways.
      drive_access(OP_READ, 32'h0000_0000);
      drive_access(OP_WRITE, 32'h0000_001C);
      for (int t = 1; t <= 4; t++) begin
         drive_access(OP_READ, t << 11);
      end
      drive_access(OP_WRITE, 32'hFFFF_FFFF);
      drive_access(OP_READ, 32'hFFFF_FFE0);
      for (int t = 5; t <= 8; t++) begin
         drive_access(OP_WRITE, (t << 11) | 32'h4);
      end
      for (int t = 9; t <= 12; t++) begin
         drive_access(OP_READ, t << 11);
      end
      drive_access(OP_READ, 32'h8000_0020);

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_setting(CSR_SPARE, 5'($urandom));

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < 7) begin
            apply_setting(fixed_off[p], fixed_idx[p], fixed_ways[p]);
         end else begin
            apply_setting($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 31));
         end
         send_random(PHASE_ACCESSES);
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d accesses over %0d cache geometries.", sb.checked, settings_used);
      $display("They gave %0d hits, %0d misses and %0d writebacks.",
               sb.hits, sb.checked - sb.hits, sb.writebacks);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("set_assoc_writeback_cache_lru_test: PASS");
      end else begin
         $display("set_assoc_writeback_cache_lru_test: FAIL");
      end
      $finish;
   end

endmodule

// ===== set_assoc_writeback_cache_lru.f =====
src/sawcl_pkg.sv
src/sawcl_ctrl.sv
src/sawcl_datapath.sv
src/set_assoc_writeback_cache_lru.sv
test/set_assoc_writeback_cache_lru_test.sv
